// ===== hw/rtl/ptbl_pkg.sv =====
// Shared types, constants and codes for the per-client token bucket limiter.
`default_nettype none
package ptbl_pkg;

	localparam int CLIENT_COUNT = 256;
	localparam int IDX_W        = $clog2(CLIENT_COUNT);

	localparam int TOKEN_W  = 32;
	localparam int TIME_W   = 32;
	localparam int FRAC_W   = 16;
	localparam int WHOLE_W  = TOKEN_W - FRAC_W;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [WHOLE_W-1:0] BURST_RESET  = WHOLE_W'(10);
	localparam logic [TOKEN_W-1:0] REFILL_RESET = TOKEN_W'(65536);

	localparam logic [CFG_IDX_W-1:0] CFG_BURST_CAPACITY  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_REFILL_PER_TICK = CFG_IDX_W'(1);

	localparam logic MODE_CHECK = 1'b0;
	localparam logic MODE_RESET = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_WB
	} fsm_state_t;

	typedef struct packed {
		logic [TOKEN_W-1:0] tokens;
		logic [TIME_W-1:0]  stamp;
	} bucket_entry_t;

	typedef struct packed {
		logic               allowed;
		logic [TOKEN_W-1:0] tokens;
	} refill_result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/per_client_token_bucket_limiter.sv =====
// Top level: sequencer, valid bits and configuration of the token bucket limiter.
// One item is handled at a time: an item taken at a clock edge goes through the
// read, multiply and write-back states and gives its result with done high in
// write-back, and busy stays high until then. The sequencer reads the bucket
// table through a registered read port, forms the 32 by 32 bit refill product
// in a register, clamps and takes a token in a second register, and writes the
// entry back while presenting the result. The result is shown for exactly one
// cycle and cannot be held off. Client valid bits are flip-flops cleared by
// reset, so no clearing pass is needed and items are taken right after reset.
// The configuration channel is always ready.
`default_nettype none
module per_client_token_bucket_limiter import ptbl_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  mode,
	input  wire logic [7:0]            client_index,
	input  wire logic [TIME_W-1:0]     now_ticks,
	output logic                       done,
	output logic                       allowed,
	output logic [WHOLE_W-1:0]         tokens_left,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	fsm_state_t state_q, state_d;

	logic [WHOLE_W-1:0]      burst_q;
	logic [TOKEN_W-1:0]      refill_q;
	logic [CLIENT_COUNT-1:0] valid_q;

	logic               mode_q;
	logic               in_range_q;
	logic [IDX_W-1:0]   addr_q;
	logic [TIME_W-1:0]  now_q;

	logic               accept;
	logic               in_range;
	logic [IDX_W-1:0]   rd_addr;
	bucket_entry_t      rd_entry;
	bucket_entry_t      wr_entry;
	logic               wr_en;
	logic               entry_ok;
	logic [TOKEN_W-1:0] cap;
	logic [TOKEN_W-1:0] base_tokens;
	logic [TIME_W-1:0]  elapsed;
	refill_result_t     result;
	logic               is_check;

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign in_range  = 32'(client_index) < 32'(CLIENT_COUNT);
	assign rd_addr   = IDX_W'(client_index);
	assign cap       = {burst_q, {FRAC_W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_WB;
			end
			ST_WB: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q  <= BURST_RESET;
			refill_q <= REFILL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BURST_CAPACITY:  burst_q  <= cfg_data[WHOLE_W-1:0];
				CFG_REFILL_PER_TICK: refill_q <= cfg_data[TOKEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q     <= mode;
			in_range_q <= in_range;
			addr_q     <= rd_addr;
			now_q      <= now_ticks;
		end
	end

	assign is_check = in_range_q && (mode_q == MODE_CHECK);
	assign wr_en    = (state_q == ST_WB) && is_check;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if ((state_q == ST_WB) && in_range_q) begin
			valid_q[addr_q] <= (mode_q == MODE_CHECK);
		end
	end

	ptbl_bucket_ram u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_q),
		.wdata (wr_entry),
		.raddr (rd_addr),
		.rdata (rd_entry)
	);

	// A client seen for the first time starts full with no elapsed time.
	always_comb begin
		entry_ok    = valid_q[addr_q];
		base_tokens = entry_ok ? rd_entry.tokens : cap;
		elapsed     = entry_ok ? (now_q - rd_entry.stamp) : '0;
	end

	ptbl_refill u_refill (
		.clk         (clk),
		.base_tokens (base_tokens),
		.elapsed     (elapsed),
		.rate        (refill_q),
		.cap         (cap),
		.result      (result)
	);

	assign wr_entry = {result.tokens, now_q};

	assign allowed     = done && is_check && result.allowed;
	assign tokens_left = (done && is_check) ? result.tokens[TOKEN_W-1:FRAC_W] : '0;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 done)
		else $error("result did not follow an accepted item");

	a_free_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after delivering a result");

	a_valid_set: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_check) |=> valid_q[addr_q])
		else $error("client entry not marked valid after a request");

	a_reset_item_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (mode_q == MODE_RESET)) |-> (!allowed && (tokens_left == '0)))
		else $error("reset item gave a nonzero result");

endmodule
`default_nettype wire

// ===== hw/rtl/ptbl_bucket_ram.sv =====
// Bucket table: one write port and one registered read port.
`default_nettype none
module ptbl_bucket_ram import ptbl_pkg::*; (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire bucket_entry_t wdata,
	input  wire logic [IDX_W-1:0] raddr,
	output bucket_entry_t      rdata
);

	bucket_entry_t mem_q [CLIENT_COUNT];
	bucket_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ptbl_refill.sv =====
// Refill datapath: registered multiply, then add, clamp and token take.
`default_nettype none
module ptbl_refill import ptbl_pkg::*; (
	input  wire logic               clk,
	input  wire logic [TOKEN_W-1:0] base_tokens,
	input  wire logic [TIME_W-1:0]  elapsed,
	input  wire logic [TOKEN_W-1:0] rate,
	input  wire logic [TOKEN_W-1:0] cap,
	output refill_result_t          result
);

	localparam int PROD_W  = TIME_W + TOKEN_W;
	localparam int LEVEL_W = PROD_W + 1;

	logic [PROD_W-1:0]  prod_s1;
	logic [TOKEN_W-1:0] base_s1;
	logic [TOKEN_W-1:0] cap_s1;
	refill_result_t     result_s2;

	logic [LEVEL_W-1:0] level;
	logic [TOKEN_W-1:0] clamped;
	refill_result_t     next_result;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(elapsed) * PROD_W'(rate);
		base_s1 <= base_tokens;
		cap_s1  <= cap;
	end

	always_comb begin
		level   = LEVEL_W'(base_s1) + LEVEL_W'(prod_s1);
		clamped = (level > LEVEL_W'(cap_s1)) ? cap_s1 : level[TOKEN_W-1:0];
		// At least one whole token is present when the integer part is nonzero.
		next_result.allowed = |clamped[TOKEN_W-1:FRAC_W];
		next_result.tokens  = clamped;
		if (next_result.allowed) begin
			next_result.tokens[TOKEN_W-1:FRAC_W] = clamped[TOKEN_W-1:FRAC_W] - WHOLE_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		result_s2 <= next_result;
	end

	assign result = result_s2;

endmodule
`default_nettype wire
